// ===== hw/rtl/aoc_pkg.sv =====
// aoc_pkg: shared types and constants for the oversampling and calibration block
// used by adc_oversample_calibrate; depends on nothing else
package aoc_pkg;

	// converter sample width and oversampling limit
	localparam int SAMPLE_BITS = 10;
	localparam int MAX_EXTEND  = 7;

	// field widths
	localparam int EXT_W   = 3;
	localparam int REF_W   = 16;
	localparam int COUNT_W = 16;
	localparam int OUT_W   = 12;
	localparam int WHOLE_W = 10;
	localparam int PART_W  = 7;

	// group counters: largest group is 4 << MAX_EXTEND samples
	localparam int GROUP_MAX = 4 << MAX_EXTEND;
	localparam int CNT_W     = $clog2(GROUP_MAX + 1);
	localparam int SUM_W     = SAMPLE_BITS + $clog2(GROUP_MAX);

	// divider
	localparam int PROD_W = COUNT_W + REF_W;
	localparam int STEP_W = $clog2(COUNT_W);
	localparam logic [REF_W-1:0] DECIMAL_BASE = REF_W'(100);
	localparam logic [REF_W-1:0] SAT_VALUE    = '1;

	// apb
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// register indexes
	typedef enum logic [2:0] {
		REG_EXTEND     = 3'd0,
		REG_LOW_VOLTS  = 3'd1,
		REG_LOW_COUNT  = 3'd2,
		REG_HIGH_VOLTS = 3'd3,
		REG_HIGH_COUNT = 3'd4
	} reg_idx_t;

	// which division the shared divider is working on
	typedef enum logic [1:0] {
		PT_LOW   = 2'd0,
		PT_HIGH  = 2'd1,
		PT_SPLIT = 2'd2
	} point_t;

	// sequencer states
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MUL  = 6'b000010,
		S_LOAD = 6'b000100,
		S_DIV  = 6'b001000,
		S_AVG  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

endpackage

// ===== hw/rtl/adc_oversample_calibrate.sv =====
// adc_oversample_calibrate: oversampling accumulator, two-point calibration and
// decimal split around one shared multiplier and one restoring divider; uses aoc_pkg
//
//   channel  signals                                     dir  beat
//   sample   sample, sample_valid, sample_ready           in   one converter result
//   result   oversampled_count, volts_hundredths,
//            whole_volts, hundredths_part,
//            result_valid, result_ready                   out  one calibrated reading
//   apb      psel, penable, pwrite, paddr, pwdata,
//            prdata, pready                               in   register access
//
// a sample that does not close its group is added to the running sum and the block stays idle
// a closing sample keeps the block busy through two passes of multiply, load and 16
// divider steps, one averaging state, a load and 16 steps for the decimal split and
// a hand-over state; a saturated or zero-reference scaling skips its 16 steps
// a finished result waits in the hand-over state for the output register
// samples are taken only while idle, also while a result waits in the output register
// reset clears registers to defaults, the running sum and the sample count
module adc_oversample_calibrate (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// sample channel
	input  logic [aoc_pkg::SAMPLE_BITS-1:0]        sample,
	input  logic                                   sample_valid,
	output logic                                   sample_ready,
	// result channel
	output logic [aoc_pkg::OUT_W-1:0]              oversampled_count,
	output logic [aoc_pkg::REF_W-1:0]              volts_hundredths,
	output logic [aoc_pkg::WHOLE_W-1:0]            whole_volts,
	output logic [aoc_pkg::PART_W-1:0]             hundredths_part,
	output logic                                   result_valid,
	input  logic                                   result_ready,
	// apb
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [aoc_pkg::ADDR_W-1:0]             paddr,
	input  logic [aoc_pkg::DATA_W-1:0]             pwdata,
	output logic [aoc_pkg::DATA_W-1:0]             prdata,
	output logic                                   pready
);

	// configuration registers
	logic [aoc_pkg::EXT_W-1:0] extend_q;
	logic [aoc_pkg::REF_W-1:0] low_volts_q;
	logic [aoc_pkg::REF_W-1:0] low_count_q;
	logic [aoc_pkg::REF_W-1:0] high_volts_q;
	logic [aoc_pkg::REF_W-1:0] high_count_q;

	// accumulator
	logic [aoc_pkg::SUM_W-1:0] sum_q;
	logic [aoc_pkg::CNT_W-1:0] cnt_q;

	// sequencer and datapath
	aoc_pkg::state_t             state_q;
	aoc_pkg::point_t             point_q;
	logic [aoc_pkg::COUNT_W-1:0] count_q;
	logic [aoc_pkg::PROD_W-1:0]  prod_q;
	logic [aoc_pkg::REF_W-1:0]   rem_q;
	logic [aoc_pkg::REF_W-1:0]   dvd_q;
	logic [aoc_pkg::REF_W-1:0]   quo_q;
	logic [aoc_pkg::STEP_W-1:0]  step_q;
	logic [aoc_pkg::REF_W-1:0]   lo_q;
	logic [aoc_pkg::REF_W-1:0]   hi_q;
	logic [aoc_pkg::REF_W-1:0]   volts_q;

	// output register
	logic                        out_valid_q;
	logic [aoc_pkg::OUT_W-1:0]   out_count_q;
	logic [aoc_pkg::REF_W-1:0]   out_volts_q;
	logic [aoc_pkg::WHOLE_W-1:0] out_whole_q;
	logic [aoc_pkg::PART_W-1:0]  out_part_q;

	logic                        cfg_wr;
	logic [2:0]                  cfg_idx;
	logic                        in_beat;
	logic [aoc_pkg::EXT_W-1:0]   ext_eff;
	logic [aoc_pkg::CNT_W-1:0]   group_size;
	logic [aoc_pkg::SUM_W-1:0]   sum_next;
	logic [aoc_pkg::CNT_W-1:0]   cnt_next;
	logic                        group_done;
	logic [aoc_pkg::SUM_W-1:0]   sum_shifted;
	logic [aoc_pkg::REF_W-1:0]   divisor;
	logic [aoc_pkg::REF_W-1:0]   mul_volts;
	logic                        load_sat;
	logic [aoc_pkg::REF_W+1:0]   trial;
	logic                        trial_ok;
	logic [aoc_pkg::REF_W-1:0]   rem_step;
	logic [aoc_pkg::REF_W-1:0]   quo_step;
	logic [aoc_pkg::REF_W:0]     avg_sum;

	// apb decode
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[4:2];

	always_comb begin
		prdata = '0;
		case (cfg_idx)
			aoc_pkg::REG_EXTEND:     prdata = aoc_pkg::DATA_W'(extend_q);
			aoc_pkg::REG_LOW_VOLTS:  prdata = aoc_pkg::DATA_W'(low_volts_q);
			aoc_pkg::REG_LOW_COUNT:  prdata = aoc_pkg::DATA_W'(low_count_q);
			aoc_pkg::REG_HIGH_VOLTS: prdata = aoc_pkg::DATA_W'(high_volts_q);
			aoc_pkg::REG_HIGH_COUNT: prdata = aoc_pkg::DATA_W'(high_count_q);
			default:                 prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extend_q     <= '0;
			low_volts_q  <= '0;
			low_count_q  <= aoc_pkg::REF_W'(1);
			high_volts_q <= '0;
			high_count_q <= aoc_pkg::REF_W'(1);
		end else if (cfg_wr) begin
			case (cfg_idx)
				aoc_pkg::REG_EXTEND:     extend_q     <= pwdata[aoc_pkg::EXT_W-1:0];
				aoc_pkg::REG_LOW_VOLTS:  low_volts_q  <= pwdata[aoc_pkg::REF_W-1:0];
				aoc_pkg::REG_LOW_COUNT:  low_count_q  <= pwdata[aoc_pkg::REF_W-1:0];
				aoc_pkg::REG_HIGH_VOLTS: high_volts_q <= pwdata[aoc_pkg::REF_W-1:0];
				aoc_pkg::REG_HIGH_COUNT: high_count_q <= pwdata[aoc_pkg::REF_W-1:0];
				default: ;
			endcase
		end
	end

	// group size from the current exponent, clamped at the limit
	always_comb begin
		ext_eff = extend_q;
		if (32'(extend_q) > aoc_pkg::MAX_EXTEND)
			ext_eff = aoc_pkg::EXT_W'(aoc_pkg::MAX_EXTEND);
	end

	assign group_size   = aoc_pkg::CNT_W'(4) << ext_eff;
	assign sample_ready = (state_q == aoc_pkg::S_IDLE);
	assign in_beat      = sample_valid && sample_ready;
	assign sum_next     = sum_q + aoc_pkg::SUM_W'(sample);
	assign cnt_next     = cnt_q + aoc_pkg::CNT_W'(1);
	assign group_done   = (cnt_next >= group_size);
	assign sum_shifted  = sum_next >> ext_eff;

	// operand selection for the shared multiplier and divider
	always_comb begin
		case (point_q)
			aoc_pkg::PT_LOW: begin
				divisor   = low_count_q;
				mul_volts = low_volts_q;
			end
			aoc_pkg::PT_HIGH: begin
				divisor   = high_count_q;
				mul_volts = high_volts_q;
			end
			default: begin
				divisor   = aoc_pkg::DECIMAL_BASE;
				mul_volts = high_volts_q;
			end
		endcase
	end

	// quotient would not fit, or no reference: saturate without dividing
	assign load_sat = (divisor == '0) ||
		(prod_q[aoc_pkg::PROD_W-1:aoc_pkg::REF_W] >= divisor);

	// one restoring step
	assign trial    = {1'b0, rem_q, dvd_q[aoc_pkg::REF_W-1]} - {2'b00, divisor};
	assign trial_ok = !trial[aoc_pkg::REF_W+1];
	assign rem_step = trial_ok ? trial[aoc_pkg::REF_W-1:0]
		: {rem_q[aoc_pkg::REF_W-2:0], dvd_q[aoc_pkg::REF_W-1]};
	assign quo_step = {quo_q[aoc_pkg::REF_W-2:0], trial_ok};

	assign avg_sum = {1'b0, lo_q} + {1'b0, hi_q};

	// accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (in_beat) begin
			if (group_done) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_next;
				cnt_q <= cnt_next;
			end
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aoc_pkg::S_IDLE;
			point_q     <= aoc_pkg::PT_LOW;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output register: load a finished reading, else drop an accepted beat
			if (state_q == aoc_pkg::S_DONE && (!out_valid_q || result_ready))
				out_valid_q <= 1'b1;
			else if (result_valid && result_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				aoc_pkg::S_IDLE: begin
					if (in_beat && group_done) begin
						state_q <= aoc_pkg::S_MUL;
						point_q <= aoc_pkg::PT_LOW;
					end
				end
				aoc_pkg::S_MUL: begin
					state_q <= aoc_pkg::S_LOAD;
				end
				aoc_pkg::S_LOAD: begin
					step_q <= '0;
					if (!load_sat)
						state_q <= aoc_pkg::S_DIV;
					else if (point_q == aoc_pkg::PT_LOW) begin
						state_q <= aoc_pkg::S_MUL;
						point_q <= aoc_pkg::PT_HIGH;
					end else
						state_q <= aoc_pkg::S_AVG;
				end
				aoc_pkg::S_DIV: begin
					step_q <= step_q + aoc_pkg::STEP_W'(1);
					if (step_q == '1) begin
						case (point_q)
							aoc_pkg::PT_LOW: begin
								state_q <= aoc_pkg::S_MUL;
								point_q <= aoc_pkg::PT_HIGH;
							end
							aoc_pkg::PT_HIGH: state_q <= aoc_pkg::S_AVG;
							default:          state_q <= aoc_pkg::S_DONE;
						endcase
					end
				end
				aoc_pkg::S_AVG: begin
					state_q <= aoc_pkg::S_LOAD;
					point_q <= aoc_pkg::PT_SPLIT;
				end
				aoc_pkg::S_DONE: begin
					if (!out_valid_q || result_ready)
						state_q <= aoc_pkg::S_IDLE;
				end
				default: state_q <= aoc_pkg::S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			aoc_pkg::S_IDLE: begin
				if (in_beat && group_done)
					count_q <= sum_shifted[aoc_pkg::COUNT_W-1:0];
			end
			aoc_pkg::S_MUL: begin
				prod_q <= aoc_pkg::PROD_W'(count_q) * aoc_pkg::PROD_W'(mul_volts);
			end
			aoc_pkg::S_LOAD: begin
				rem_q <= prod_q[aoc_pkg::PROD_W-1:aoc_pkg::REF_W];
				dvd_q <= prod_q[aoc_pkg::REF_W-1:0];
				quo_q <= '0;
				if (load_sat) begin
					if (point_q == aoc_pkg::PT_LOW)
						lo_q <= aoc_pkg::SAT_VALUE;
					else
						hi_q <= aoc_pkg::SAT_VALUE;
				end
			end
			aoc_pkg::S_DIV: begin
				rem_q <= rem_step;
				dvd_q <= {dvd_q[aoc_pkg::REF_W-2:0], 1'b0};
				quo_q <= quo_step;
				if (step_q == '1) begin
					if (point_q == aoc_pkg::PT_LOW)
						lo_q <= quo_step;
					else if (point_q == aoc_pkg::PT_HIGH)
						hi_q <= quo_step;
				end
			end
			aoc_pkg::S_AVG: begin
				volts_q <= avg_sum[aoc_pkg::REF_W:1];
				prod_q  <= aoc_pkg::PROD_W'(avg_sum[aoc_pkg::REF_W:1]);
			end
			aoc_pkg::S_DONE: begin
				if (!out_valid_q || result_ready) begin
					out_count_q <= count_q[aoc_pkg::OUT_W-1:0];
					out_volts_q <= volts_q;
					out_whole_q <= quo_q[aoc_pkg::WHOLE_W-1:0];
					out_part_q  <= rem_q[aoc_pkg::PART_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign result_valid      = out_valid_q;
	assign oversampled_count = out_count_q;
	assign volts_hundredths  = out_volts_q;
	assign whole_volts       = out_whole_q;
	assign hundredths_part   = out_part_q;

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) < aoc_pkg::GROUP_MAX)
		else $error("sample count beyond largest group");

	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != aoc_pkg::S_DIV) |-> (step_q == '0))
		else $error("divider step count not cleared outside division");

	a_rise_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == aoc_pkg::S_DONE))
		else $error("result shown without finished sequence");

	a_split: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (hundredths_part < aoc_pkg::PART_W'(100)) &&
		(32'(whole_volts) * 32'd100 + 32'(hundredths_part) == 32'(volts_hundredths)))
		else $error("decimal split inconsistent with voltage");

endmodule
